[src/feal4_pkg.sv]
// Shared types and functions of the FEAL-4 whitened block cipher.
// Holds the pipeline stage record, register indexes and the G function.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package feal4_pkg;

    localparam int unsigned HALF_W = 32;
    localparam int unsigned CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_KEY_M1 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_M2 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_M3 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_N1 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_N2 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_N3 = 3'd5;

    localparam logic CMD_ENCRYPT = 1'b0;
    localparam logic CMD_DECRYPT = 1'b1;

    typedef struct packed {
        logic              valid;
        logic              cmd;
        logic [HALF_W-1:0] x;
        logic [HALF_W-1:0] y;
    } t_stage;

    function automatic logic [7:0] rot2_sum(input logic [7:0] a, input logic [7:0] b,
                                            input logic carry);
        logic [7:0] s;
        s = a + b + {7'd0, carry};
        return {s[5:0], s[7:6]};
    endfunction

    function automatic logic [HALF_W-1:0] g_fun(input logic [HALF_W-1:0] a);
        logic [7:0] d1;
        logic [7:0] d2;
        logic [7:0] c0;
        logic [7:0] c1;
        logic [7:0] c2;
        logic [7:0] c3;
        d1 = a[31:24] ^ a[23:16];
        d2 = a[15:8] ^ a[7:0];
        c1 = rot2_sum(d1, d2, 1'b1);
        c2 = rot2_sum(d2, c1, 1'b0);
        c0 = rot2_sum(a[31:24], c1, 1'b0);
        c3 = rot2_sum(a[7:0], c2, 1'b1);
        return {c0, c1, c2, c3};
    endfunction

endpackage

`default_nettype wire

[src/feal4_round_cell.sv]
// One round cell of the FEAL-4 chain: applies G to one half and folds it into the other.
// Depends on feal4_pkg for the stage record and the G function.
`timescale 1ns / 1ps
`default_nettype none

module feal4_round_cell (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_en,
    input  wire logic                      i_odd,
    input  wire logic [feal4_pkg::HALF_W-1:0] i_key_enc,
    input  wire logic [feal4_pkg::HALF_W-1:0] i_key_dec,
    input  wire feal4_pkg::t_stage         i_stage,
    output feal4_pkg::t_stage              o_stage
);

    feal4_pkg::t_stage              r_stage;
    feal4_pkg::t_stage              n_stage;
    logic                           w_upd_x;
    logic [feal4_pkg::HALF_W-1:0]   w_key;
    logic [feal4_pkg::HALF_W-1:0]   w_g;

    always_comb begin
        w_upd_x = i_odd ^ i_stage.cmd ^ 1'b1;
        w_key   = (i_stage.cmd == feal4_pkg::CMD_DECRYPT) ? i_key_dec : i_key_enc;
        w_g     = feal4_pkg::g_fun((w_upd_x ? i_stage.y : i_stage.x) ^ w_key);
        n_stage = i_stage;
        if (w_upd_x) begin
            n_stage.x = i_stage.x ^ w_g;
        end else begin
            n_stage.y = i_stage.y ^ w_g;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage.valid <= 1'b0;
        end else if (i_en) begin
            r_stage.valid <= n_stage.valid;
        end
        if (i_en) begin
            r_stage.cmd <= n_stage.cmd;
            r_stage.x   <= n_stage.x;
            r_stage.y   <= n_stage.y;
        end
    end

    assign o_stage = r_stage;

endmodule

`default_nettype wire

[src/feal4_whitened_block_cipher.sv]
// Top level of the FEAL-4 whitened block cipher: key registers, whitening and the cell chain.
// Depends on feal4_pkg and feal4_round_cell.
//
// Usage: key words M1..M3 and N1..N3 are written over the configuration channel
// (index 0..5, others ignored; o_cfg_ready is always high) while the block is idle.
// Each slave beat carries a 64-bit block in tdata (left half in the upper bits) and
// the command in tuser: 0 encrypts, 1 decrypts. Each master beat returns one block.
// The datapath is a chain of six registers: input whitening, four round cells with
// one G function each, and output whitening. One beat is accepted every cycle
// while the output register does not hold an untaken beat.
// When the receiver stalls, the whole chain holds and o_s_tready drops only while
// the output register holds an untaken beat; no beat is lost or duplicated.
// Reset clears all valid flags and the six key words to zero.
`timescale 1ns / 1ps
`default_nettype none

module feal4_whitened_block_cipher (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [feal4_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [31:0]                     i_cfg_data,
    input  wire logic                            i_s_tvalid,
    output logic                                 o_s_tready,
    input  wire logic [63:0]                     i_s_tdata,  // [63:0] block_in
    input  wire logic                            i_s_tuser,  // [0] cmd
    output logic                                 o_m_tvalid,
    input  wire logic                            i_m_tready,
    output logic [63:0]                          o_m_tdata   // [63:0] block_out
);

    localparam int unsigned NUM_CELLS = 4;

    logic [31:0]       r_key_m1;
    logic [31:0]       r_key_m2;
    logic [31:0]       r_key_m3;
    logic [31:0]       r_key_n1;
    logic [31:0]       r_key_n2;
    logic [31:0]       r_key_n3;
    feal4_pkg::t_stage r_in;
    feal4_pkg::t_stage n_in;
    feal4_pkg::t_stage w_chain [NUM_CELLS+1];
    logic              r_out_valid;
    logic [63:0]       r_out_data;
    logic [63:0]       n_out_data;
    logic              w_en;
    logic [31:0]       w_hi;
    logic [31:0]       w_lo;
    logic [31:0]       w_ol;
    logic [31:0]       w_or;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_m1 <= '0;
            r_key_m2 <= '0;
            r_key_m3 <= '0;
            r_key_n1 <= '0;
            r_key_n2 <= '0;
            r_key_n3 <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                feal4_pkg::REG_KEY_M1: r_key_m1 <= i_cfg_data;
                feal4_pkg::REG_KEY_M2: r_key_m2 <= i_cfg_data;
                feal4_pkg::REG_KEY_M3: r_key_m3 <= i_cfg_data;
                feal4_pkg::REG_KEY_N1: r_key_n1 <= i_cfg_data;
                feal4_pkg::REG_KEY_N2: r_key_n2 <= i_cfg_data;
                feal4_pkg::REG_KEY_N3: r_key_n3 <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_en       = !r_out_valid || i_m_tready;
    assign o_s_tready = w_en;

    always_comb begin
        w_hi        = i_s_tdata[63:32];
        w_lo        = i_s_tdata[31:0];
        n_in.valid  = i_s_tvalid;
        n_in.cmd    = i_s_tuser;
        if (i_s_tuser == feal4_pkg::CMD_DECRYPT) begin
            n_in.x = w_lo ^ w_hi ^ r_key_m3;
            n_in.y = w_hi ^ r_key_n3;
        end else begin
            n_in.x = w_hi ^ r_key_m1;
            n_in.y = w_hi ^ w_lo ^ r_key_n1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in.valid <= 1'b0;
        end else if (w_en) begin
            r_in.valid <= n_in.valid;
        end
        if (w_en) begin
            r_in.cmd <= n_in.cmd;
            r_in.x   <= n_in.x;
            r_in.y   <= n_in.y;
        end
    end

    assign w_chain[0] = r_in;

    for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
        feal4_round_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_en      (w_en),
            .i_odd     ((i % 2) == 1),
            .i_key_enc ((i == 2) ? r_key_m2 : ((i == 3) ? r_key_n2 : 32'd0)),
            .i_key_dec ((i == 0) ? r_key_n2 : ((i == 1) ? r_key_m2 : 32'd0)),
            .i_stage   (w_chain[i]),
            .o_stage   (w_chain[i+1])
        );
    end

    always_comb begin
        if (w_chain[NUM_CELLS].cmd == feal4_pkg::CMD_DECRYPT) begin
            w_ol = w_chain[NUM_CELLS].x ^ r_key_m1;
            w_or = w_chain[NUM_CELLS].y ^ w_ol ^ r_key_n1;
        end else begin
            w_ol = w_chain[NUM_CELLS].y ^ r_key_n3;
            w_or = w_chain[NUM_CELLS].x ^ r_key_m3 ^ w_ol;
        end
        n_out_data = {w_ol, w_or};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_chain[NUM_CELLS].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule

`default_nettype wire

[test/feal4_checker.sv]
// Checker for the FEAL-4 whitened block cipher: tracks key writes, predicts each block
// from the accepted input beats and compares it with the returned beats in order.
// Depends on feal4_pkg for register indexes and command codes.
`timescale 1ns / 1ps

module feal4_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    input  logic                            i_cfg_ready,
    input  logic [feal4_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]                     i_cfg_data,
    input  logic                            i_s_tvalid,
    input  logic                            i_s_tready,
    input  logic [63:0]                     i_s_tdata,
    input  logic                            i_s_tuser,
    input  logic                            i_m_tvalid,
    input  logic                            i_m_tready,
    input  logic [63:0]                     i_m_tdata,
    output int                              o_fail_count,
    output int                              o_pending
);

    localparam int MAX_REPORTS = 10;

    logic [31:0] km1, km2, km3, kn1, kn2, kn3;
    logic [63:0] expected_blocks[$];

    function automatic logic [7:0] add_rotl2(input logic [7:0] a, input logic [7:0] b,
                                             input logic carry);
        logic [7:0] s;
        s = a + b + {7'd0, carry};
        return (s << 2) | (s >> 6);
    endfunction

    function automatic logic [31:0] feal_g(input logic [31:0] w);
        logic [7:0] b0, b3, t1, t2, c0, c1, c2, c3;
        b0 = w[31:24];
        b3 = w[7:0];
        t1 = b0 ^ w[23:16];
        t2 = w[15:8] ^ b3;
        c1 = add_rotl2(t1, t2, 1'b1);
        c2 = add_rotl2(t2, c1, 1'b0);
        c0 = add_rotl2(b0, c1, 1'b0);
        c3 = add_rotl2(b3, c2, 1'b1);
        return {c0, c1, c2, c3};
    endfunction

    function automatic logic [63:0] feal4_predict(input logic cmd, input logic [63:0] blk);
        logic [31:0] lh, rh, x0, y0, x1, y1, x2, y2, out_l, out_r;
        lh = blk[63:32];
        rh = blk[31:0];
        if (cmd == feal4_pkg::CMD_ENCRYPT) begin
            x0 = lh ^ km1;
            y0 = lh ^ rh ^ kn1;
            x1 = x0 ^ feal_g(y0);
            y1 = y0 ^ feal_g(x1);
            x2 = x1 ^ feal_g(y1 ^ km2);
            y2 = y1 ^ feal_g(x2 ^ kn2);
            out_l = y2 ^ kn3;
            out_r = x2 ^ km3 ^ out_l;
        end else begin
            y2 = lh ^ kn3;
            x2 = rh ^ lh ^ km3;
            y1 = y2 ^ feal_g(x2 ^ kn2);
            x1 = x2 ^ feal_g(y1 ^ km2);
            y0 = y1 ^ feal_g(x1);
            x0 = x1 ^ feal_g(y0);
            out_l = x0 ^ km1;
            out_r = y0 ^ out_l ^ kn1;
        end
        return {out_l, out_r};
    endfunction

    always @(posedge i_clk) begin : monitor
        logic [63:0] want;
        if (!i_rst_n) begin
            km1 = '0;
            km2 = '0;
            km3 = '0;
            kn1 = '0;
            kn2 = '0;
            kn3 = '0;
            expected_blocks.delete();
            o_fail_count = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    feal4_pkg::REG_KEY_M1: km1 = i_cfg_data;
                    feal4_pkg::REG_KEY_M2: km2 = i_cfg_data;
                    feal4_pkg::REG_KEY_M3: km3 = i_cfg_data;
                    feal4_pkg::REG_KEY_N1: kn1 = i_cfg_data;
                    feal4_pkg::REG_KEY_N2: kn2 = i_cfg_data;
                    feal4_pkg::REG_KEY_N3: kn3 = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_m_tvalid && i_m_tready) begin
                if (expected_blocks.size() == 0) begin
                    if (o_fail_count < MAX_REPORTS)
                        $display("unexpected output beat %h with no block pending", i_m_tdata);
                    o_fail_count++;
                end else begin
                    want = expected_blocks.pop_front();
                    if (want !== i_m_tdata) begin
                        if (o_fail_count < MAX_REPORTS)
                            $display("block_out mismatch: expected %h, actual %h",
                                     want, i_m_tdata);
                        o_fail_count++;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready)
                expected_blocks.push_back(feal4_predict(i_s_tuser, i_s_tdata));
        end
        o_pending = expected_blocks.size();
    end

endmodule

[test/tb_feal4_whitened_block_cipher.sv]
// Testbench top for the FEAL-4 whitened block cipher: drives key writes and input beats
// under several idle and stall patterns and gives the verdict.
// Depends on feal4_pkg, feal4_whitened_block_cipher and feal4_checker.
`timescale 1ns / 1ps

module tb_feal4_whitened_block_cipher;

    localparam logic [feal4_pkg::CFG_IDX_W-1:0] REG_UNMAPPED_LO = 3'd6;
    localparam logic [feal4_pkg::CFG_IDX_W-1:0] REG_UNMAPPED_HI = 3'd7;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 12;
    localparam int PHASE_BLOCKS = 200;
    localparam int LONG_HOLD = 100;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_cfg_valid;
    logic                            o_cfg_ready;
    logic [feal4_pkg::CFG_IDX_W-1:0] i_cfg_index;
    logic [31:0]                     i_cfg_data;
    logic                            i_s_tvalid;
    logic                            o_s_tready;
    logic [63:0]                     i_s_tdata;
    logic                            i_s_tuser;
    logic                            o_m_tvalid;
    logic                            i_m_tready;
    logic [63:0]                     o_m_tdata;

    int fail_count;
    int pending_blocks;
    int send_idle_pct = 0;
    int rx_stall_pct = 0;
    int rx_hold_len = 0;

    feal4_whitened_block_cipher u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    feal4_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .i_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .i_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .i_m_tdata   (o_m_tdata),
        .o_fail_count(fail_count),
        .o_pending   (pending_blocks)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        int hold;
        hold = 0;
        i_m_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_len != 0) begin
                hold = rx_hold_len;
                rx_hold_len = 0;
            end
            if (hold != 0) begin
                i_m_tready <= 1'b0;
                hold--;
            end else begin
                i_m_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
            end
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) ||
                (i_cfg_valid && o_cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("== FAIL ==");
        $finish;
    end

    function automatic logic [63:0] rand_block();
        logic [63:0] v;
        v = {$urandom(), $urandom()};
        if ($urandom_range(0, 9) == 0) begin
            for (int i = 0; i < 8; i++)
                v[8*i +: 8] = {8{v[8*i]}};
        end
        return v;
    endfunction

    function automatic logic [31:0] rand_key();
        logic [31:0] k;
        case ($urandom_range(0, 7))
            0: k = 32'h0000_0000;
            1: k = 32'hFFFF_FFFF;
            default: k = $urandom();
        endcase
        return k;
    endfunction

    task automatic wait_drained();
        while (pending_blocks != 0)
            @(negedge i_clk);
    endtask

    task automatic cfg_write(input logic [feal4_pkg::CFG_IDX_W-1:0] idx,
                             input logic [31:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic program_keys(input logic [31:0] m1, input logic [31:0] m2,
                                input logic [31:0] m3, input logic [31:0] n1,
                                input logic [31:0] n2, input logic [31:0] n3,
                                input logic stray);
        wait_drained();
        cfg_write(feal4_pkg::REG_KEY_M1, m1);
        cfg_write(feal4_pkg::REG_KEY_M2, m2);
        cfg_write(feal4_pkg::REG_KEY_M3, m3);
        cfg_write(feal4_pkg::REG_KEY_N1, n1);
        cfg_write(feal4_pkg::REG_KEY_N2, n2);
        cfg_write(feal4_pkg::REG_KEY_N3, n3);
        if (stray) begin
            cfg_write(REG_UNMAPPED_LO, $urandom());
            cfg_write(REG_UNMAPPED_HI, $urandom());
        end
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_block(input logic cmd, input logic [63:0] blk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= blk;
        i_s_tuser <= cmd;
        @(posedge i_clk);
        while (!o_s_tready)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic random_phase(input int idle_pct, input int stall_pct, input logic squeeze);
        program_keys(rand_key(), rand_key(), rand_key(), rand_key(), rand_key(), rand_key(),
                     $urandom_range(0, 1));
        send_idle_pct = idle_pct;
        rx_stall_pct = stall_pct;
        if (squeeze) begin
            fork
                begin
                    repeat (10) @(posedge i_clk);
                    rx_hold_len = LONG_HOLD;
                end
            join_none
        end
        for (int i = 0; i < PHASE_BLOCKS; i++)
            send_block($urandom_range(0, 1) ? feal4_pkg::CMD_DECRYPT : feal4_pkg::CMD_ENCRYPT,
                       rand_block());
        i_s_tvalid <= 1'b0;
        wait_drained();
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = feal4_pkg::REG_KEY_M1;
        i_cfg_data = '0;
        i_s_tvalid = 1'b0;
        i_s_tdata = '0;
        i_s_tuser = feal4_pkg::CMD_ENCRYPT;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Keys at their reset value.
        send_block(feal4_pkg::CMD_ENCRYPT, 64'h0000_0000_0000_0000);
        send_block(feal4_pkg::CMD_ENCRYPT, 64'hFFFF_FFFF_FFFF_FFFF);
        send_block(feal4_pkg::CMD_DECRYPT, 64'h0000_0000_0000_0000);
        send_block(feal4_pkg::CMD_DECRYPT, 64'hFFFF_FFFF_FFFF_FFFF);
        send_block(feal4_pkg::CMD_ENCRYPT, 64'h8000_0001_0000_0080);
        i_s_tvalid <= 1'b0;

        // All-ones keys; the writes to unmapped indexes must leave them untouched.
        program_keys('1, '1, '1, '1, '1, '1, 1'b1);
        send_block(feal4_pkg::CMD_ENCRYPT, 64'h0000_0000_0000_0000);
        send_block(feal4_pkg::CMD_ENCRYPT, 64'hFFFF_FFFF_FFFF_FFFF);
        send_block(feal4_pkg::CMD_DECRYPT, 64'h0000_0000_0000_0000);
        send_block(feal4_pkg::CMD_DECRYPT, 64'hFFFF_FFFF_FFFF_FFFF);
        send_block(feal4_pkg::CMD_ENCRYPT, 64'hAAAA_AAAA_5555_5555);
        send_block(feal4_pkg::CMD_DECRYPT, 64'h5555_5555_AAAA_AAAA);
        i_s_tvalid <= 1'b0;

        // Distinct keys with byte patterns that make the byte sums wrap.
        program_keys(32'h0123_4567, 32'h89AB_CDEF, 32'hFEDC_BA98, 32'h7654_3210,
                     32'hFF00_FF00, 32'h00FF_00FF, 1'b0);
        send_block(feal4_pkg::CMD_ENCRYPT, 64'hFF00_FF00_00FF_00FF);
        send_block(feal4_pkg::CMD_DECRYPT, 64'hFF00_FF00_00FF_00FF);
        send_block(feal4_pkg::CMD_ENCRYPT, 64'h7F80_7F80_807F_807F);
        send_block(feal4_pkg::CMD_DECRYPT, 64'h0123_4567_89AB_CDEF);
        send_block(feal4_pkg::CMD_ENCRYPT, 64'hFFFF_FFFF_0000_0000);
        send_block(feal4_pkg::CMD_DECRYPT, 64'h0000_0000_FFFF_FFFF);
        i_s_tvalid <= 1'b0;

        random_phase(0, 0, 1'b0);
        random_phase(65, 0, 1'b0);
        random_phase(0, 65, 1'b0);
        random_phase(37, 37, 1'b0);
        random_phase(0, 0, 1'b1);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

[feal4_whitened_block_cipher.f]
src/feal4_pkg.sv
src/feal4_round_cell.sv
src/feal4_whitened_block_cipher.sv
test/feal4_checker.sv
test/tb_feal4_whitened_block_cipher.sv
